// ----- sv/td_tracked_incremental_pd_heater_top_defines.svh -----
// Assertion macros shared by the heater drive block.
`ifndef TD_TRACKED_INCREMENTAL_PD_HEATER_TOP_DEFINES_SVH
`define TD_TRACKED_INCREMENTAL_PD_HEATER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDPH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tdph_pkg.sv -----
// Shared widths, register codes, sequencer states and saturation helpers.
package tdph_pkg;

    localparam int ST_W   = 48;
    localparam int SUM_W  = 52;
    localparam int IN_W   = 16;
    localparam int GAIN_W = 24;
    localparam int OUT_W  = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_RATE_GAIN  = 2'd1;
    localparam logic [1:0] REG_MAX_OUTPUT = 2'd2;

    localparam logic [OUT_W-1:0] DRIVE_MIN   = 16'd100;
    localparam logic [OUT_W-1:0] MAX_OUT_RST = 16'hFFFF;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-ST_W+1){1'b1}}, {(ST_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_A0,
        S_RAD_GO,
        S_RAD,
        S_SQRT,
        S_PICK,
        S_CHOOSE,
        S_DECIDE,
        S_DIV,
        S_FH_GO,
        S_FH,
        S_P_GO,
        S_P,
        S_T,
        S_SUM,
        S_FIN
    } t_state;

    // Saturate a wide signed sum to the 48 bit state range.
    function automatic logic signed [ST_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI) begin
            sat48 = ST_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            sat48 = ST_W'(SAT_LO);
        end else begin
            sat48 = ST_W'(v);
        end
    endfunction

    // Give a magnitude the requested sign in the wide sum format.
    function automatic logic signed [SUM_W-1:0] apply_sign(input logic neg,
                                                          input logic [ST_W-1:0] mag);
        logic signed [SUM_W-1:0] m;
        m = $signed(SUM_W'(mag));
        apply_sign = neg ? -m : m;
    endfunction

    function automatic logic [ST_W-1:0] abs_st(input logic signed [ST_W-1:0] v);
        abs_st = v[ST_W-1] ? ST_W'(-v) : ST_W'(v);
    endfunction

    function automatic logic [SUM_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
        abs_sum = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

endpackage

// ----- sv/tdph_mul_serial.sv -----
// Shift-add multiplier that retires one multiplier bit per cycle.
module tdph_mul_serial #(
    parameter int A_W = 48,
    parameter int B_W = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     r_a;
    logic [A_W+B_W-1:0] r_p;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [A_W:0]       sum;

    // The low half of the product register holds the multiplier bits still to go.
    assign sum = {1'b0, r_p[A_W+B_W-1:B_W]} + (r_p[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {sum, r_p[B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

// ----- sv/tdph_sqrt_serial.sv -----
// Restoring integer square root, one root bit per cycle.
module tdph_sqrt_serial #(
    parameter int RAD_W = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [RAD_W-1:0]   i_rad,
    output logic               o_done,
    output logic [RAD_W/2-1:0] o_root
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W+3:0] rem_t;
    logic [ROOT_W+3:0] trial;
    logic              fits;

    assign rem_t = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign fits  = (rem_t >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= fits ? (ROOT_W+2)'(rem_t - trial) : (ROOT_W+2)'(rem_t);
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- sv/tdph_div_serial.sv -----
// Restoring division of a fraction by a fixed divisor, one quotient bit per cycle.
module tdph_div_serial #(
    parameter int          N_W     = 12,
    parameter int          Q_W     = 24,
    parameter int unsigned DIVISOR = 2416
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    output logic           o_done,
    output logic [Q_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(Q_W + 1);
    localparam logic [N_W:0] DIV_C = (N_W+1)'(DIVISOR);

    logic [N_W:0]     r_rem;
    logic [Q_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [N_W:0]     rem2;
    logic             take;

    // The numerator stays below the divisor, so the doubled remainder fits.
    assign rem2 = {r_rem[N_W-1:0], 1'b0};
    assign take = (rem2 >= DIV_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= take ? (rem2 - DIV_C) : rem2;
            r_q   <= {r_q[Q_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ----- sv/td_tracked_incremental_pd_heater_top.sv -----
// Heater drive controller: tracking differentiator with fhan and an incremental PD step.
// Each sample transfer brings a setpoint and a measured temperature (signed Q8.8). The error
// drives a second-order tracking differentiator (Han's fhan, r = 1, h = 0.012) whose tracked
// error and error rate are kept as 48 bit signed values with FRAC_BITS fraction bits and
// saturate at that range. The drive accumulator then gains prop_gain * tracked error plus
// rate_gain * rate (both gains unsigned Q16.8), is clamped as a signed value to
// [100, max_output], and is forced to max_output while the tracked error exceeds 1.5; the new
// accumulator value is the drive of the result transfer. The block works on one sample at a
// time and takes no new input transfer until that sample is done. It uses one shared
// bit-serial multiplier five times per sample, with operand width B_W = 24 (or the width of h
// when that is larger), a bit-serial square root whose radicand width RAD_W is the fhan
// radicand width rounded up to even, and a bit-serial divider by the constant r*h*h that is
// skipped when fhan saturates. A finished drive value waits in an output register, so the
// next sample is taken while it is still stalled. The gains and max_output sit on an
// APB-style port at byte addresses 0, 4 and 8; pready is always high.
`include "td_tracked_incremental_pd_heater_top_defines.svh"

module td_tracked_incremental_pd_heater_top #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [tdph_pkg::IN_W-1:0]    i_setpoint,
    input  logic signed [tdph_pkg::IN_W-1:0]    i_measured,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic        [tdph_pkg::OUT_W-1:0]   o_drive,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [tdph_pkg::ADDR_W-1:0]  paddr,
    input  logic        [tdph_pkg::DATA_W-1:0]  pwdata,
    output logic        [tdph_pkg::DATA_W-1:0]  prdata,
    output logic                                pready
);
    import tdph_pkg::*;

    // Fixed-point constants: h and d = r*h*h, rounded to FRAC_BITS fraction bits.
    localparam longint unsigned HQ_L =
        ((64'(12) << FRAC_BITS) + 64'(500)) / 64'(1000);
    localparam longint unsigned DQ_L =
        ((64'(144) << FRAC_BITS) + 64'(500000)) / 64'(1000000);
    localparam int HQ_W    = $clog2(HQ_L + 1);
    localparam int DQ_W    = $clog2(DQ_L + 1);
    localparam int B_W     = (HQ_W > GAIN_W) ? HQ_W : GAIN_W;
    localparam int M_W     = ST_W + B_W;
    localparam int RAD_W0  = DQ_W + 52;
    localparam int RAD_W   = RAD_W0 + (RAD_W0 % 2);
    localparam int ROOT_W  = RAD_W / 2;

    localparam logic [B_W-1:0]          HQ_B     = B_W'(HQ_L);
    localparam logic [B_W-1:0]          DQ_B     = B_W'(DQ_L);
    localparam logic [RAD_W-1:0]        DQ2      = RAD_W'(DQ_L * DQ_L);
    localparam logic [ROOT_W-1:0]       DQ_R     = ROOT_W'(DQ_L);
    localparam logic [ST_W-1:0]         DQ_ST    = ST_W'(DQ_L);
    localparam logic [SUM_W-1:0]        DQ_SUM   = SUM_W'(DQ_L);
    localparam logic signed [ST_W-1:0]  FH_ONE   = ST_W'(64'(1) << FRAC_BITS);
    localparam logic signed [ST_W-1:0]  TE_FORCE = ST_W'(64'(3) << (FRAC_BITS - 1));
    localparam logic [M_W-1:0]          P_MASK   = (M_W'(1) << (FRAC_BITS + 8)) - M_W'(1);

    // Sequencer and architectural state.
    t_state                   r_state, n_state;
    logic signed [ST_W-1:0]   r_te, n_te;
    logic signed [ST_W-1:0]   r_er, n_er;
    logic [OUT_W-1:0]         r_acc, n_acc;
    logic                     r_out_valid, n_out_valid;
    logic [OUT_W-1:0]         r_drive, n_drive;
    logic [GAIN_W-1:0]        r_prop;
    logic [GAIN_W-1:0]        r_rate;
    logic [OUT_W-1:0]         r_max;

    // Per-sample working registers.
    logic signed [ST_W-1:0]   r_x, n_x;
    logic signed [ST_W-1:0]   r_a0, n_a0;
    logic signed [ST_W-1:0]   r_y, n_y;
    logic [ROOT_W-1:0]        r_a1, n_a1;
    logic signed [SUM_W-1:0]  r_a2, n_a2;
    logic signed [SUM_W-1:0]  r_a_sum, n_a_sum;
    logic signed [SUM_W-1:0]  r_a, n_a;
    logic signed [ST_W-1:0]   r_fh, n_fh;
    logic signed [SUM_W-1:0]  r_p, n_p;
    logic signed [SUM_W-1:0]  r_t, n_t;
    logic                     r_fp_pos, n_fp_pos;
    logic                     r_fp_neg, n_fp_neg;
    logic signed [SUM_W-1:0]  r_s, n_s;

    // Shared arithmetic units.
    logic                     mul_start;
    logic [ST_W-1:0]          mul_a;
    logic [B_W-1:0]           mul_b;
    logic                     mul_done;
    logic [M_W-1:0]           mul_prod;
    logic                     sqrt_start;
    logic [RAD_W-1:0]         sqrt_rad;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;
    logic                     div_start;
    logic [DQ_W-1:0]          div_num;
    logic                     div_done;
    logic [FRAC_BITS-1:0]     div_quot;

    logic                     in_xfer;
    logic                     out_xfer;
    logic                     cfg_wr;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;

    tdph_mul_serial #(
        .A_W (ST_W),
        .B_W (B_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    tdph_sqrt_serial #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (sqrt_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    tdph_div_serial #(
        .N_W     (DQ_W),
        .Q_W     (FRAC_BITS),
        .DIVISOR (32'(DQ_L))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer: next state, unit operands and next values of every working register.
    always_comb begin
        logic signed [IN_W:0]     diff;
        logic signed [SUM_W-1:0]  err;
        logic [ST_W-1:0]          mag_f;
        logic [ST_W-1:0]          mag_f8;
        logic signed [SUM_W-1:0]  a0s;
        logic signed [SUM_W-1:0]  half_s;
        logic [ROOT_W-1:0]        a1_less;
        logic signed [SUM_W-1:0]  mid3;
        logic signed [SUM_W-1:0]  mid;
        logic [ST_W-1:0]          ay;
        logic [SUM_W-1:0]         mag_a;
        logic signed [SUM_W-1:0]  max_s;
        logic signed [SUM_W-1:0]  clamp;
        logic                     fp_nz;

        diff    = (IN_W+1)'(i_setpoint) - (IN_W+1)'(i_measured);
        err     = SUM_W'(diff) <<< (FRAC_BITS - 8);
        mag_f   = ST_W'(mul_prod >> FRAC_BITS);
        mag_f8  = ST_W'(mul_prod >> (FRAC_BITS + 8));
        a0s     = apply_sign(r_er[ST_W-1], mag_f);
        a1_less = r_a1 - DQ_R;
        half_s  = $signed(SUM_W'(a1_less >> 1));
        mid3    = r_a_sum + r_a2;
        mid     = mid3[SUM_W-1] ? ((mid3 + SUM_W'(1)) >>> 1) : (mid3 >>> 1);
        ay      = abs_st(r_y);
        mag_a   = abs_sum(r_a);
        max_s   = $signed(SUM_W'(r_max));
        fp_nz   = |(mul_prod & P_MASK);
        clamp   = r_s;

        n_state     = r_state;
        n_te        = r_te;
        n_er        = r_er;
        n_acc       = r_acc;
        n_out_valid = out_xfer ? 1'b0 : r_out_valid;
        n_drive     = r_drive;
        n_x         = r_x;
        n_a0        = r_a0;
        n_y         = r_y;
        n_a1        = r_a1;
        n_a2        = r_a2;
        n_a_sum     = r_a_sum;
        n_a         = r_a;
        n_fh        = r_fh;
        n_p         = r_p;
        n_t         = r_t;
        n_fp_pos    = r_fp_pos;
        n_fp_neg    = r_fp_neg;
        n_s         = r_s;

        mul_start  = 1'b0;
        mul_a      = abs_st(r_er);
        mul_b      = HQ_B;
        sqrt_start = 1'b0;
        sqrt_rad   = DQ2 + (RAD_W'(mul_prod) << 3);
        div_start  = 1'b0;
        div_num    = DQ_W'(mag_a);

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    // x = tracked error minus new error; start h * rate.
                    n_x       = sat48(SUM_W'(r_te) - err);
                    mul_start = 1'b1;
                    n_state   = S_A0;
                end
            end
            S_A0: begin
                if (mul_done) begin
                    n_a0    = ST_W'(a0s);
                    n_y     = sat48(SUM_W'(r_x) + a0s);
                    n_state = S_RAD_GO;
                end
            end
            S_RAD_GO: begin
                mul_start = 1'b1;
                mul_a     = ay;
                mul_b     = DQ_B;
                n_state   = S_RAD;
            end
            S_RAD: begin
                if (mul_done) begin
                    sqrt_start = 1'b1;
                    n_state    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    n_a1    = sqrt_root;
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                // The tracked error moves by h times the old rate, which is a0.
                n_te    = sat48(SUM_W'(r_te) + SUM_W'(r_a0));
                n_a_sum = SUM_W'(r_a0) + SUM_W'(r_y);
                if (r_y[ST_W-1]) begin
                    n_a2 = SUM_W'(r_a0) - half_s;
                end else if (r_y != '0) begin
                    n_a2 = SUM_W'(r_a0) + half_s;
                end else begin
                    n_a2 = SUM_W'(r_a0);
                end
                n_state = S_CHOOSE;
            end
            S_CHOOSE: begin
                // Inside the linear zone a = a0 + y; on its edge the two forms are averaged.
                if (ay < DQ_ST) begin
                    n_a = r_a_sum;
                end else if (ay > DQ_ST) begin
                    n_a = r_a2;
                end else begin
                    n_a = mid;
                end
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (mag_a >= DQ_SUM) begin
                    n_fh    = r_a[SUM_W-1] ? FH_ONE : -FH_ONE;
                    n_state = S_FH_GO;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_fh    = r_a[SUM_W-1] ? $signed(ST_W'(div_quot))
                                           : -$signed(ST_W'(div_quot));
                    n_state = S_FH_GO;
                end
            end
            S_FH_GO: begin
                mul_start = 1'b1;
                mul_a     = abs_st(r_fh);
                n_state   = S_FH;
            end
            S_FH: begin
                if (mul_done) begin
                    n_er    = sat48(SUM_W'(r_er) + apply_sign(r_fh[ST_W-1], mag_f));
                    n_state = S_P_GO;
                end
            end
            S_P_GO: begin
                mul_start = 1'b1;
                mul_a     = abs_st(r_te);
                mul_b     = B_W'(r_prop);
                n_state   = S_P;
            end
            S_P: begin
                if (mul_done) begin
                    n_p       = apply_sign(r_te[ST_W-1], mag_f8);
                    n_fp_pos  = fp_nz && !r_te[ST_W-1];
                    n_fp_neg  = fp_nz && r_te[ST_W-1];
                    mul_start = 1'b1;
                    mul_a     = abs_st(r_er);
                    mul_b     = B_W'(r_rate);
                    n_state   = S_T;
                end
            end
            S_T: begin
                if (mul_done) begin
                    n_t     = apply_sign(r_er[ST_W-1], mag_f8);
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_s = $signed(SUM_W'(r_acc)) + r_p + r_t;
                // A truncated proportional term pulls the sum back toward zero by one.
                if (r_fp_pos && n_s[SUM_W-1]) begin
                    n_s = n_s + SUM_W'(1);
                end else if (r_fp_neg && !n_s[SUM_W-1] && n_s != '0) begin
                    n_s = n_s - SUM_W'(1);
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (r_s > max_s) begin
                    clamp = max_s;
                end else if (r_s < $signed(SUM_W'(DRIVE_MIN))) begin
                    clamp = $signed(SUM_W'(DRIVE_MIN));
                end
                if (r_te > TE_FORCE) begin
                    clamp = max_s;
                end
                if (!r_out_valid || !i_stall) begin
                    n_acc       = OUT_W'(clamp);
                    n_drive     = OUT_W'(clamp);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_te        <= '0;
            r_er        <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_prop      <= '0;
            r_rate      <= '0;
            r_max       <= MAX_OUT_RST;
        end else begin
            r_state     <= n_state;
            r_te        <= n_te;
            r_er        <= n_er;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_PROP_GAIN:  r_prop <= pwdata[GAIN_W-1:0];
                    REG_RATE_GAIN:  r_rate <= pwdata[GAIN_W-1:0];
                    REG_MAX_OUTPUT: r_max  <= pwdata[OUT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_drive  <= n_drive;
        r_x      <= n_x;
        r_a0     <= n_a0;
        r_y      <= n_y;
        r_a1     <= n_a1;
        r_a2     <= n_a2;
        r_a_sum  <= n_a_sum;
        r_a      <= n_a;
        r_fh     <= n_fh;
        r_p      <= n_p;
        r_t      <= n_t;
        r_fp_pos <= n_fp_pos;
        r_fp_neg <= n_fp_neg;
        r_s      <= n_s;
    end

    // Register read back; the low two address bits select bytes and are ignored.
    always_comb begin
        case (paddr[3:2])
            REG_PROP_GAIN:  prdata = DATA_W'(r_prop);
            REG_RATE_GAIN:  prdata = DATA_W'(r_rate);
            REG_MAX_OUTPUT: prdata = DATA_W'(r_max);
            default:        prdata = '0;
        endcase
    end

    assign pready  = 1'b1;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

    `TDPH_ASSERT_SAME(a_drive_range, i_clk, i_rst_n, o_valid, (o_drive >= DRIVE_MIN) || (o_drive == r_max), "drive outside clamp range")
    `TDPH_ASSERT_SAME(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_FIN, "result appeared outside the final step")
    `TDPH_ASSERT_NEXT(a_mul_owner, i_clk, i_rst_n, mul_start, r_state == S_A0 || r_state == S_RAD || r_state == S_FH || r_state == S_P || r_state == S_T, "multiplier started without a waiting state")

endmodule
